// ----- rtl/core/qrs_pkg.sv -----
`timescale 1ns / 1ps

package qrs_pkg;

  localparam int IO_BITS = 32;
  localparam int KIND_BITS = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_INFINITE = 3'd0,
    KIND_NONE     = 3'd1,
    KIND_LINEAR   = 3'd2,
    KIND_TWO      = 3'd3,
    KIND_DOUBLE   = 3'd4,
    KIND_NEGATIVE = 3'd5
  } kind_t;

endpackage

// ----- rtl/core/qrs_coef_if.sv -----
`timescale 1ns / 1ps

interface qrs_coef_if;
  import qrs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [IO_BITS-1:0] coef_quad;
  logic signed [IO_BITS-1:0] coef_lin;
  logic signed [IO_BITS-1:0] coef_const;

  modport source (output valid, coef_quad, coef_lin, coef_const, input ready);
  modport sink (input valid, coef_quad, coef_lin, coef_const, output ready);
endinterface

// ----- rtl/core/qrs_root_if.sv -----
`timescale 1ns / 1ps

interface qrs_root_if;
  import qrs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KIND_BITS-1:0]      solution_kind;
  logic signed [IO_BITS-1:0] root_first;
  logic signed [IO_BITS-1:0] root_second;
  logic                      saturated;

  modport source (output valid, solution_kind, root_first, root_second, saturated,
                  input ready);
  modport sink (input valid, solution_kind, root_first, root_second, saturated,
                output ready);
endinterface

// ----- rtl/core/quadratic_root_solver.sv -----
`timescale 1ns / 1ps

// Solves a*x^2 + b*x + c = 0 for one coefficient triple per request.
// The in_ch channel takes coef_quad, coef_lin and coef_const as signed
// fixed-point words; only the low WORD_BITS bits of each are used. The out_ch
// channel returns the solution kind, up to two roots in the same format, and
// a flag that is set when a root was clamped to the word range.
// The block is a single pipeline that takes a new request in every cycle
// while out_ch is not stalled. Its length is set by the square root, which
// resolves one root bit per stage, and by the two dividers, which resolve one
// quotient bit per stage. Throughput is one result per cycle while not stalled.
// Reset empties the pipeline; no result is pending afterwards.
// When the receiver holds out_ch.ready low with a result waiting, the whole
// pipeline stops and in_ch.ready falls in the same cycle; nothing is lost or
// repeated, and work resumes as soon as the result is taken.

module quadratic_root_solver #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  qrs_coef_if.sink    in_ch,
  qrs_root_if.source  out_ch
);
  import qrs_pkg::*;

  localparam int W      = WORD_BITS;
  localparam int DW     = 2 * W + 2;
  localparam int RT_W   = W + 1;
  localparam int DEN_W  = W + 1;
  localparam int NUM_W  = W + 1 + FRAC_BITS;
  localparam int TAG_W  = KIND_BITS + 3 * W;
  localparam int DTAG_W = KIND_BITS + 2;
  localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(1) << (W - 1);
  localparam logic [NUM_W-1:0] POS_LIM = NEG_LIM - NUM_W'(1);

  logic adv;

  logic             dc_vld;
  logic [DW-1:0]    dc_disc;
  logic [TAG_W-1:0] dc_tag;

  logic             sq_vld;
  logic [RT_W-1:0]  sq_root;
  logic [TAG_W-1:0] sq_tag;

  kind_t               sq_kind;
  logic signed [W-1:0] sq_a, sq_b, sq_c;
  logic [W-1:0]        mag_a, mag_b;
  logic signed [W+1:0] nb, nc, sx, n1, n2, m1, m2;
  logic                linear;
  kind_t               kind_nxt;

  logic              d_vld_r;
  kind_t             d_kind_r;
  logic [NUM_W-1:0]  d_num1_r, d_num2_r;
  logic [DEN_W-1:0]  d_den_r;
  logic              d_neg1_r, d_neg2_r;

  logic              dv_vld;
  logic [NUM_W-1:0]  q1, q2;
  logic [DTAG_W-1:0] dv_tag;

  kind_t                 e_kind;
  logic                  e_neg1, e_neg2;
  logic                  ov1, ov2;
  logic [W-1:0]          r1w, r2w;
  logic signed [IO_BITS-1:0] r1_nxt, r2_nxt;
  logic                  sat_nxt;

  logic                      out_vld_r;
  kind_t                     out_kind_r;
  logic signed [IO_BITS-1:0] out_r1_r, out_r2_r;
  logic                      out_sat_r;

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  qrs_disc #(.W(W)) u_disc (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (in_ch.valid),
    .in_a     (in_ch.coef_quad[W-1:0]),
    .in_b     (in_ch.coef_lin[W-1:0]),
    .in_c     (in_ch.coef_const[W-1:0]),
    .out_vld  (dc_vld),
    .out_disc (dc_disc),
    .out_tag  (dc_tag)
  );

  qrs_sqrt #(.VAL_W(DW), .TAG_W(TAG_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (dc_vld),
    .in_val   (dc_disc),
    .in_tag   (dc_tag),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  always_comb begin
    sq_kind = kind_t'(sq_tag[TAG_W-1 -: KIND_BITS]);
    sq_a    = sq_tag[3*W-1 -: W];
    sq_b    = sq_tag[2*W-1 -: W];
    sq_c    = sq_tag[W-1:0];
    mag_a   = sq_a[W-1] ? W'(-sq_a) : W'(sq_a);
    mag_b   = sq_b[W-1] ? W'(-sq_b) : W'(sq_b);
    linear  = sq_kind == KIND_LINEAR;
    nb      = -{{2{sq_b[W-1]}}, sq_b};
    nc      = -{{2{sq_c[W-1]}}, sq_c};
    sx      = {1'b0, sq_root};
    n1      = linear ? nc : nb + sx;
    n2      = nb - sx;
    m1      = n1[W+1] ? -n1 : n1;
    m2      = n2[W+1] ? -n2 : n2;
    kind_nxt = (sq_kind == KIND_TWO && sq_root == '0) ? KIND_DOUBLE : sq_kind;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_kind_r <= kind_nxt;
      d_num1_r <= {m1[W:0], {FRAC_BITS{1'b0}}};
      d_num2_r <= {m2[W:0], {FRAC_BITS{1'b0}}};
      d_den_r  <= linear ? {1'b0, mag_b} : {mag_a, 1'b0};
      d_neg1_r <= n1[W+1] ^ (linear ? sq_b[W-1] : sq_a[W-1]);
      d_neg2_r <= n2[W+1] ^ sq_a[W-1];
    end
  end

  qrs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .TAG_W(DTAG_W)) u_div_first (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (d_vld_r),
    .in_num  (d_num1_r),
    .in_den  (d_den_r),
    .in_tag  ({d_kind_r, d_neg1_r, d_neg2_r}),
    .out_vld (dv_vld),
    .out_quo (q1),
    .out_tag (dv_tag)
  );

  qrs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .TAG_W(1)) u_div_second (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (d_vld_r),
    .in_num  (d_num2_r),
    .in_den  (d_den_r),
    .in_tag  (1'b0),
    .out_vld (),
    .out_quo (q2),
    .out_tag ()
  );

  always_comb begin
    e_kind = kind_t'(dv_tag[DTAG_W-1 -: KIND_BITS]);
    e_neg1 = dv_tag[1];
    e_neg2 = dv_tag[0];
    if (e_neg1) begin
      ov1 = q1 > NEG_LIM;
      r1w = ov1 ? W'(-NEG_LIM) : W'(-q1);
    end else begin
      ov1 = q1 > POS_LIM;
      r1w = ov1 ? POS_LIM[W-1:0] : q1[W-1:0];
    end
    if (e_neg2) begin
      ov2 = q2 > NEG_LIM;
      r2w = ov2 ? W'(-NEG_LIM) : W'(-q2);
    end else begin
      ov2 = q2 > POS_LIM;
      r2w = ov2 ? POS_LIM[W-1:0] : q2[W-1:0];
    end
    r1_nxt  = '0;
    r2_nxt  = '0;
    sat_nxt = 1'b0;
    case (e_kind)
      KIND_TWO: begin
        r1_nxt  = IO_BITS'($signed(r1w));
        r2_nxt  = IO_BITS'($signed(r2w));
        sat_nxt = ov1 | ov2;
      end
      KIND_LINEAR, KIND_DOUBLE: begin
        r1_nxt  = IO_BITS'($signed(r1w));
        sat_nxt = ov1;
      end
      default: begin
        r1_nxt  = '0;
        r2_nxt  = '0;
        sat_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_kind_r <= e_kind;
      out_r1_r   <= r1_nxt;
      out_r2_r   <= r2_nxt;
      out_sat_r  <= sat_nxt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.solution_kind = out_kind_r;
  assign out_ch.root_first    = out_r1_r;
  assign out_ch.root_second   = out_r2_r;
  assign out_ch.saturated     = out_sat_r;
endmodule

// ----- rtl/core/qrs_disc.sv -----
`timescale 1ns / 1ps

module qrs_disc #(
  parameter int W = qrs_pkg::WORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic signed [W-1:0]              in_a,
  input  logic signed [W-1:0]              in_b,
  input  logic signed [W-1:0]              in_c,
  output logic                             out_vld,
  output logic [2*W+1:0]                   out_disc,
  output logic [qrs_pkg::KIND_BITS+3*W-1:0] out_tag
);
  import qrs_pkg::*;

  localparam int DW = 2 * W + 2;

  logic                vld_a_r;
  logic signed [W-1:0] a_a_r, b_a_r, c_a_r;
  logic [W-1:0]        ma_a_r, mb_a_r, mc_a_r;

  logic                vld_b_r;
  logic signed [W-1:0] a_b_r, b_b_r, c_b_r;
  logic [2*W-1:0]      bb_b_r, p_b_r;
  logic                diff_b_r;

  logic                vld_c_r;
  logic [DW-1:0]       disc_c_r;
  kind_t               kind_c_r;
  logic signed [W-1:0] a_c_r, b_c_r, c_c_r;

  logic [DW-1:0]       p4, bbx, disc_nxt;
  logic                neg_disc;
  kind_t               kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_a_r    <= in_a;
      b_a_r    <= in_b;
      c_a_r    <= in_c;
      ma_a_r   <= in_a[W-1] ? W'(-in_a) : W'(in_a);
      mb_a_r   <= in_b[W-1] ? W'(-in_b) : W'(in_b);
      mc_a_r   <= in_c[W-1] ? W'(-in_c) : W'(in_c);
      a_b_r    <= a_a_r;
      b_b_r    <= b_a_r;
      c_b_r    <= c_a_r;
      bb_b_r   <= mb_a_r * mb_a_r;
      p_b_r    <= ma_a_r * mc_a_r;
      diff_b_r <= a_a_r[W-1] ^ c_a_r[W-1];
      disc_c_r <= disc_nxt;
      kind_c_r <= kind_nxt;
      a_c_r    <= a_b_r;
      b_c_r    <= b_b_r;
      c_c_r    <= c_b_r;
    end
  end

  always_comb begin
    p4  = {p_b_r, 2'b00};
    bbx = {2'b00, bb_b_r};
    if (diff_b_r) begin
      neg_disc = 1'b0;
      disc_nxt = bbx + p4;
    end else begin
      neg_disc = p4 > bbx;
      disc_nxt = bbx - p4;
    end
    if (a_b_r == '0) begin
      if (b_b_r == '0) begin
        kind_nxt = (c_b_r == '0) ? KIND_INFINITE : KIND_NONE;
      end else begin
        kind_nxt = KIND_LINEAR;
      end
    end else begin
      kind_nxt = neg_disc ? KIND_NEGATIVE : KIND_TWO;
    end
  end

  assign out_vld  = vld_c_r;
  assign out_disc = disc_c_r;
  assign out_tag  = {kind_c_r, a_c_r, b_c_r, c_c_r};
endmodule

// ----- rtl/core/qrs_sqrt.sv -----
`timescale 1ns / 1ps

module qrs_sqrt #(
  parameter int VAL_W = 2 * qrs_pkg::WORD_BITS_DEF + 2,
  parameter int TAG_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [VAL_W-1:0]   in_val,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               out_vld,
  output logic [VAL_W/2-1:0] out_root,
  output logic [TAG_W-1:0]   out_tag
);
  localparam int RT_W = VAL_W / 2;
  localparam int CUR_W = RT_W + 3;

  logic             vld_r  [RT_W];
  logic [VAL_W-1:0] val_r  [RT_W];
  logic [RT_W:0]    rem_r  [RT_W];
  logic [RT_W-1:0]  root_r [RT_W];
  logic [TAG_W-1:0] tag_r  [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    logic             vld_src;
    logic [VAL_W-1:0] val_src;
    logic [RT_W:0]    rem_src;
    logic [RT_W-1:0]  root_src;
    logic [TAG_W-1:0] tag_src;
    logic [CUR_W-1:0] cur, trial, diff;
    logic             ge;
    logic [RT_W:0]    rem_nxt;
    logic [RT_W-1:0]  root_nxt;

    if (k == 0) begin : g_first
      assign vld_src  = in_vld;
      assign val_src  = in_val;
      assign rem_src  = '0;
      assign root_src = '0;
      assign tag_src  = in_tag;
    end else begin : g_next
      assign vld_src  = vld_r[k-1];
      assign val_src  = val_r[k-1];
      assign rem_src  = rem_r[k-1];
      assign root_src = root_r[k-1];
      assign tag_src  = tag_r[k-1];
    end

    always_comb begin
      cur      = {rem_src, val_src[VAL_W-1 -: 2]};
      trial    = {1'b0, root_src, 2'b01};
      diff     = cur - trial;
      ge       = cur >= trial;
      rem_nxt  = ge ? diff[RT_W:0] : cur[RT_W:0];
      root_nxt = {root_src[RT_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val_r[k]  <= val_src << 2;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        tag_r[k]  <= tag_src;
      end
    end
  end

  assign out_vld  = vld_r[RT_W-1];
  assign out_root = root_r[RT_W-1];
  assign out_tag  = tag_r[RT_W-1];
endmodule

// ----- rtl/core/qrs_div.sv -----
`timescale 1ns / 1ps

module qrs_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 33,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [NUM_W-1:0] out_quo,
  output logic [TAG_W-1:0] out_tag
);
  logic             vld_r [NUM_W];
  logic [NUM_W-1:0] num_r [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];
  logic [TAG_W-1:0] tag_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic             vld_src;
    logic [NUM_W-1:0] num_src;
    logic [DEN_W-1:0] rem_src, den_src;
    logic [TAG_W-1:0] tag_src;
    logic [DEN_W:0]   cur, diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_src = in_vld;
      assign num_src = in_num;
      assign rem_src = '0;
      assign den_src = in_den;
      assign tag_src = in_tag;
    end else begin : g_next
      assign vld_src = vld_r[k-1];
      assign num_src = num_r[k-1];
      assign rem_src = rem_r[k-1];
      assign den_src = den_r[k-1];
      assign tag_src = tag_r[k-1];
    end

    always_comb begin
      cur  = {rem_src, num_src[NUM_W-1]};
      diff = cur - {1'b0, den_src};
      ge   = cur >= {1'b0, den_src};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= {num_src[NUM_W-2:0], ge};
        rem_r[k] <= ge ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
        den_r[k] <= den_src;
        tag_r[k] <= tag_src;
      end
    end
  end

  assign out_vld = vld_r[NUM_W-1];
  assign out_quo = num_r[NUM_W-1];
  assign out_tag = tag_r[NUM_W-1];
endmodule
